// File: src/cbeq_pkg.sv
// shared types, constants and lookup functions for the click-wheel event queue
package cbeq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int REM_W       = 5;

  localparam logic [15:0] PRESS_WORD   = 16'h4000;
  localparam logic [15:0] RELEASE_WORD = 16'h8000;
  localparam logic [15:0] SCROLL_WORD  = 16'h1000;
  localparam logic [6:0]  IMG_RELEASED = 7'h7f;
  localparam logic [7:0]  SCROLL_NEG   = 8'h80;
  localparam logic [7:0]  HOLD_MASK    = 8'h20;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // mask bit for each button pin 0..6
  localparam logic [7:0] PIN_TO_MASK [7] = '{8'h40, 8'h08, 8'h02, 8'h04, 8'h01, 8'h10, 8'h80};

  typedef struct packed {
    logic        w0_vld;
    logic [15:0] w0;
    logic        w1_vld;
    logic [15:0] w1;
    logic        rd;
  } cmd_t;

  // previous phase that makes the current phase one step forward
  function automatic logic [1:0] fwd_prev(input logic [1:0] ph);
    logic [1:0] r;
    begin
      case (ph)
        2'd0:    r = 2'd1;
        2'd1:    r = 2'd3;
        2'd2:    r = 2'd0;
        2'd3:    r = 2'd2;
        default: r = 2'd0;
      endcase
      return r;
    end
  endfunction

  // previous phase that makes the current phase one step back
  function automatic logic [1:0] back_prev(input logic [1:0] ph);
    logic [1:0] r;
    begin
      case (ph)
        2'd0:    r = 2'd2;
        2'd1:    r = 2'd0;
        2'd2:    r = 2'd3;
        2'd3:    r = 2'd1;
        default: r = 2'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/cbeq_front.sv
// front end: button, hold and wheel tracking, builds queue commands
module cbeq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_fire,
  input  logic               kind,
  input  logic [7:0]         button_pins,
  input  logic [1:0]         wheel_pins,
  input  logic               button_irq,
  input  logic               wheel_irq,
  output cbeq_pkg::cmd_t     cmd,
  output logic               cmd_vld
);

  logic              enabled_r;
  logic [7:0]        mask_r, mask_nxt;
  logic [6:0]        img_r, img_nxt;
  logic              hold_r, hold_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic signed [7:0] scroll_r, scroll_nxt;
  logic signed [8:0] sum;
  logic [7:0]        gained, lost, mag;

  always_comb begin
    mask_nxt   = mask_r;
    img_nxt    = img_r;
    hold_nxt   = hold_r;
    phase_nxt  = phase_r;
    scroll_nxt = scroll_r;
    sum        = {scroll_r[7], scroll_r};
    gained     = '0;
    lost       = '0;
    mag        = '0;
    cmd        = '0;
    if (kind != cbeq_pkg::KIND_READ) begin
      if (button_irq) begin
        if (button_pins[7] != hold_r) begin
          hold_nxt    = button_pins[7];
          mask_nxt[5] = button_pins[7];
        end
        if (!hold_nxt) begin
          for (int b = 0; b < 7; b++) begin
            if (img_r[b] ^ button_pins[b]) begin
              if (!button_pins[b]) mask_nxt = mask_nxt | cbeq_pkg::PIN_TO_MASK[b];
              else mask_nxt = mask_nxt & ~cbeq_pkg::PIN_TO_MASK[b];
            end
          end
          img_nxt = button_pins[6:0];
        end
      end
      if (wheel_irq) begin
        if (!hold_nxt) begin
          if (phase_r == cbeq_pkg::fwd_prev(wheel_pins)) sum = sum + 9'sd1;
          else if (phase_r == cbeq_pkg::back_prev(wheel_pins)) sum = sum - 9'sd1;
        end
        phase_nxt = wheel_pins;
      end
      if (sum > 9'sd127) scroll_nxt = 8'sd127;
      else if (sum < -9'sd127) scroll_nxt = -8'sd127;
      else scroll_nxt = sum[7:0];
      gained    = mask_nxt & ~mask_r;
      lost      = mask_r & ~mask_nxt;
      cmd.w0_vld = enabled_r && (gained != '0);
      cmd.w0     = cbeq_pkg::PRESS_WORD | {8'h00, gained};
      cmd.w1_vld = enabled_r && (lost != '0);
      cmd.w1     = cbeq_pkg::RELEASE_WORD | {8'h00, lost};
    end else begin
      if (scroll_r[7]) mag = cbeq_pkg::SCROLL_NEG | {1'b0, 7'(-scroll_r)};
      else mag = {1'b0, scroll_r[6:0]};
      cmd.w0_vld = enabled_r && (scroll_r != '0);
      cmd.w0     = cbeq_pkg::SCROLL_WORD | {8'h00, mag};
      cmd.rd     = 1'b1;
      scroll_nxt = '0;
    end
  end

  assign cmd_vld = in_fire && (cmd.rd || cmd.w0_vld || cmd.w1_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      mask_r    <= '0;
      img_r     <= cbeq_pkg::IMG_RELEASED;
      hold_r    <= 1'b0;
      phase_r   <= '0;
      scroll_r  <= '0;
    end else begin
      if (cfg_wr_en) enabled_r <= cfg_wr_data;
      if (in_fire) begin
        mask_r   <= mask_nxt;
        img_r    <= img_nxt;
        hold_r   <= hold_nxt;
        phase_r  <= phase_nxt;
        scroll_r <= scroll_nxt;
      end
    end
  end

endmodule

// File: src/cbeq_cmd_fifo.sv
// two-entry command queue between front end and event store
module cbeq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cbeq_pkg::cmd_t wr_cmd,
  output logic           full,
  output logic           rd_vld,
  input  logic           rd_en,
  output cbeq_pkg::cmd_t rd_cmd
);

  cbeq_pkg::cmd_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign rd_vld = (cnt_r != 2'd0);
  assign rd_cmd = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// File: src/cbeq_back.sv
// back end: event store, pushes, pops and the result register
module cbeq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_vld,
  input  cbeq_pkg::cmd_t cmd,
  output logic           cmd_rd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [23:0]    out_tdata,  // event_word, remaining, overflowed, zero pad
  output logic           out_tuser   // has_event
);

  localparam logic [cbeq_pkg::PTR_W-1:0] LAST = cbeq_pkg::PTR_W'(cbeq_pkg::QUEUE_DEPTH - 1);

  logic [15:0]                 store_r [cbeq_pkg::QUEUE_DEPTH];
  logic [cbeq_pkg::PTR_W-1:0]  wp_r, wp_nxt, wp1, rp_r, rp_nxt;
  logic [cbeq_pkg::PTR_W-1:0]  cnt_r, cnt_nxt, cnt1, cnt2;
  logic                        drop_r, drop_nxt;
  logic                        ok0, ok1, has, bypass, go;
  logic                        out_vld_r;
  logic [15:0]                 word_r;
  logic                        has_r;
  logic [cbeq_pkg::REM_W-1:0]  rem_r;
  logic                        ovf_r;

  function automatic logic [cbeq_pkg::PTR_W-1:0] nxt_slot(input logic [cbeq_pkg::PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign cmd_rd = cmd_vld && (!cmd.rd || !out_vld_r || out_tready);
  assign go     = cmd_rd;

  always_comb begin
    ok0      = cmd.w0_vld && (cnt_r != LAST);
    cnt1     = cnt_r + cbeq_pkg::PTR_W'(ok0);
    wp1      = ok0 ? nxt_slot(wp_r) : wp_r;
    ok1      = cmd.w1_vld && (cnt1 != LAST);
    cnt2     = cnt1 + cbeq_pkg::PTR_W'(ok1);
    wp_nxt   = ok1 ? nxt_slot(wp1) : wp1;
    has      = cmd.rd && (cnt2 != '0);
    bypass   = (cnt_r == '0);
    rp_nxt   = has ? nxt_slot(rp_r) : rp_r;
    cnt_nxt  = cnt2 - cbeq_pkg::PTR_W'(has);
    drop_nxt = drop_r || (cmd.w0_vld && !ok0) || (cmd.w1_vld && !ok1);
  end

  always_ff @(posedge clk) begin
    if (go && ok0) store_r[wp_r] <= cmd.w0;
    if (go && ok1) store_r[wp1] <= cmd.w1;
    if (go && cmd.rd) begin
      if (!has) word_r <= '0;
      else if (bypass) word_r <= cmd.w0;
      else word_r <= store_r[rp_r];
      has_r <= has;
      rem_r <= cbeq_pkg::REM_W'(cnt_nxt);
      ovf_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (go) begin
        wp_r   <= wp_nxt;
        rp_r   <= rp_nxt;
        cnt_r  <= cnt_nxt;
        drop_r <= drop_nxt;
      end
      if (go && cmd.rd) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, ovf_r, rem_r, word_r};
  assign out_tuser  = has_r;

endmodule

// File: src/clickwheel_button_event_queue_core.sv
// top level of the click-wheel and button event queue
// Takes one item per cycle while in_tready is high: a pin sample (in_tuser 0) updates the
// hold switch, the seven buttons and the quadrature wheel and may queue a press and a release
// word; a read (in_tuser 1) queues any pending scroll word and returns one transfer with the
// popped word. The front end classifies an item in the cycle it is accepted and hands a
// command to a two-entry queue; the back end retires one command per cycle against the
// 31-word event store unless a read waits on a held result register. A read result is
// registered in the command queue and then in the result register. in_tready drops only while
// the command queue is full, which happens when the result register is held by out_tready. A
// push into a full store is dropped and sets the sticky overflow bit until reset.
module clickwheel_button_event_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // enabled
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // button_pins, wheel_pins, button_irq, wheel_irq, zero pad
  input  logic        in_tuser,     // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // event_word, remaining, overflowed, zero pad
  output logic        out_tuser     // has_event
);

  cbeq_pkg::cmd_t new_cmd, head_cmd;
  logic           new_vld, q_full, head_vld, head_rd, in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  cbeq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .kind        (in_tuser),
    .button_pins (in_tdata[7:0]),
    .wheel_pins  (in_tdata[9:8]),
    .button_irq  (in_tdata[10]),
    .wheel_irq   (in_tdata[11]),
    .cmd         (new_cmd),
    .cmd_vld     (new_vld)
  );

  cbeq_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (new_vld),
    .wr_cmd (new_cmd),
    .full   (q_full),
    .rd_vld (head_vld),
    .rd_en  (head_rd),
    .rd_cmd (head_cmd)
  );

  cbeq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_vld    (head_vld),
    .cmd        (head_cmd),
    .cmd_rd     (head_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: test/clickwheel_event_checker.sv
// checker for the click-wheel event queue: predicts read results and compares them
`timescale 1ns / 100ps
module clickwheel_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          waiting
);

  localparam int STORE_SLOTS = cbeq_pkg::QUEUE_DEPTH - 1;
  localparam int SHOWN_LIMIT = 10;

  // phase reached by one step forward / back from the indexed phase
  localparam logic [1:0] STEP_FWD  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] STEP_BACK [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
  // pressed-mask bit for button pins 0..6
  localparam logic [7:0] BUTTON_BIT [7] = '{8'h40, 8'h08, 8'h02, 8'h04, 8'h01, 8'h10, 8'h80};

  typedef struct packed {
    logic [15:0] word;
    logic        has_event;
    logic [4:0]  left;
    logic        dropped;
  } read_result_t;

  logic         enabled_q;
  logic [7:0]   mask_q;
  logic [6:0]   image_q;
  logic         hold_q;
  logic [1:0]   phase_q;
  int           scroll_q;
  logic         drop_q;
  logic [15:0]  event_fifo[$];
  read_result_t read_results[$];

  function automatic void queue_event(input logic [15:0] w);
    if (!enabled_q) return;
    if (event_fifo.size() >= STORE_SLOTS) drop_q = 1'b1;
    else event_fifo.push_back(w);
  endfunction

  function automatic void bump_scroll(input int d);
    scroll_q += d;
    if (scroll_q > 127) scroll_q = 127;
    if (scroll_q < -127) scroll_q = -127;
  endfunction

  function automatic void take_sample(input logic [7:0] pins, input logic [1:0] wheel,
                                      input logic b_irq, input logic w_irq);
    logic [7:0] next_mask;
    logic [7:0] gained;
    logic [7:0] lost;
    logic [6:0] changed;
    next_mask = mask_q;
    if (b_irq) begin
      if (pins[7] != hold_q) begin
        next_mask = pins[7] ? (next_mask | cbeq_pkg::HOLD_MASK)
                            : (next_mask & ~cbeq_pkg::HOLD_MASK);
        hold_q = pins[7];
      end
      if (!hold_q) begin
        changed = image_q ^ pins[6:0];
        for (int b = 0; b < 7; b++) begin
          if (changed[b]) begin
            next_mask = pins[b] ? (next_mask & ~BUTTON_BIT[b]) : (next_mask | BUTTON_BIT[b]);
          end
        end
        image_q = pins[6:0];
      end
    end
    if (w_irq) begin
      if (!hold_q) begin
        if (wheel == STEP_FWD[phase_q]) bump_scroll(1);
        else if (wheel == STEP_BACK[phase_q]) bump_scroll(-1);
      end
      phase_q = wheel;
    end
    gained = next_mask & ~mask_q;
    lost   = mask_q & ~next_mask;
    if (gained != 8'h00) queue_event(cbeq_pkg::PRESS_WORD | {8'h00, gained});
    if (lost != 8'h00) queue_event(cbeq_pkg::RELEASE_WORD | {8'h00, lost});
    mask_q = next_mask;
  endfunction

  function automatic void take_read();
    read_result_t r;
    logic [7:0]   code;
    if (scroll_q != 0) begin
      if (scroll_q < 0) code = cbeq_pkg::SCROLL_NEG | 8'(-scroll_q);
      else code = 8'(scroll_q);
      queue_event(cbeq_pkg::SCROLL_WORD | {8'h00, code});
      scroll_q = 0;
    end
    if (event_fifo.size() == 0) begin
      r.word      = 16'h0000;
      r.has_event = 1'b0;
    end else begin
      r.word      = event_fifo.pop_front();
      r.has_event = 1'b1;
    end
    r.left    = 5'(event_fifo.size());
    r.dropped = drop_q;
    read_results.push_back(r);
  endfunction

  function automatic void check_result();
    read_result_t r;
    if (read_results.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOWN_LIMIT) begin
        $display("mismatch: transfer with no read pending, got word %h has %b left %0d ovf %b",
                 out_tdata[15:0], out_tuser, out_tdata[20:16], out_tdata[21]);
      end
      return;
    end
    r = read_results.pop_front();
    if (out_tdata[15:0] !== r.word || out_tuser !== r.has_event ||
        out_tdata[20:16] !== r.left || out_tdata[21] !== r.dropped) begin
      fail_count++;
      if (fail_count <= SHOWN_LIMIT) begin
        $display("mismatch: exp word %h has %b left %0d ovf %b, got word %h has %b left %0d ovf %b",
                 r.word, r.has_event, r.left, r.dropped,
                 out_tdata[15:0], out_tuser, out_tdata[20:16], out_tdata[21]);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      enabled_q = 1'b0;
      mask_q    = 8'h00;
      image_q   = cbeq_pkg::IMG_RELEASED;
      hold_q    = 1'b0;
      phase_q   = 2'd0;
      scroll_q  = 0;
      drop_q    = 1'b0;
      event_fifo.delete();
      read_results.delete();
    end else begin
      if (cfg_wr_en) enabled_q = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == cbeq_pkg::KIND_READ) take_read();
        else take_sample(in_tdata[7:0], in_tdata[9:8], in_tdata[10], in_tdata[11]);
      end
      if (out_tvalid && out_tready) check_result();
    end
    waiting = read_results.size();
  end

endmodule

// File: test/tb_clickwheel_button_event_queue_core.sv
// testbench top: drives pin samples and reads into the click-wheel event queue
`timescale 1ns / 100ps
module tb_clickwheel_button_event_queue_core;

  localparam int   STALL_LIMIT      = 2000;
  localparam int   SETTLE_CYCLES    = 8;
  localparam int   LONG_HOLD_CYCLES = 300;
  localparam logic KIND_PIN         = cbeq_pkg::KIND_SAMPLE;

  localparam logic [1:0] STEP_FWD  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] STEP_BACK [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  logic        rx_long_hold;
  logic        quiet;
  logic [7:0]  pins_now;
  logic [1:0]  phase_now;
  int          idle_run;
  int          fail_count;
  int          waiting;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  clickwheel_button_event_queue_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  clickwheel_event_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .waiting     (waiting)
  );

  task automatic send(input logic kind, input logic [7:0] pins, input logic [1:0] wheel,
                      input logic b_irq, input logic w_irq);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, w_irq, b_irq, wheel, pins};
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_PIN) begin
      if (b_irq) pins_now = pins;
      if (w_irq) phase_now = wheel;
    end
  endtask

  task automatic sample(input logic [7:0] pins, input logic [1:0] wheel,
                        input logic b_irq, input logic w_irq);
    send(KIND_PIN, pins, wheel, b_irq, w_irq);
  endtask

  task automatic read_one();
    send(cbeq_pkg::KIND_READ, 8'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic wheel_step(input logic forward);
    sample(pins_now, forward ? STEP_FWD[phase_now] : STEP_BACK[phase_now], 1'b0, 1'b1);
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_enable(input logic on);
    drain(SETTLE_CYCLES);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_item();
    int         pick;
    int         way;
    int         bit_sel;
    logic [7:0] pins;
    logic [1:0] wheel;
    pick = $urandom_range(0, 99);
    pins = pins_now;
    if (pick < 30) begin
      read_one();
    end else if (pick < 88) begin
      if (pins[7] ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 29) == 0)) begin
        pins[7] = ~pins[7];
      end else if ($urandom_range(0, 2) != 0) begin
        bit_sel = $urandom_range(0, 6);
        pins[bit_sel] = ~pins[bit_sel];
      end
      way = $urandom_range(0, 9);
      if (way < 5) wheel = STEP_FWD[phase_now];
      else if (way < 8) wheel = STEP_BACK[phase_now];
      else wheel = 2'($urandom);
      sample(pins, wheel, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
    end else begin
      sample(8'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rx_long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 16'h0000;
    in_tuser     = 1'b0;
    rx_long_hold = 1'b0;
    quiet        = 1'b0;
    pins_now     = 8'h7f;
    phase_now    = 2'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_enable(1'b1);

    // directed part
    read_one();
    sample(8'h7f, 2'd0, 1'b1, 1'b1);
    sample(8'h00, 2'd0, 1'b1, 1'b1);
    sample(8'hff, 2'd2, 1'b1, 1'b1);
    sample(8'h7f, phase_now, 1'b1, 1'b0);
    repeat (4) read_one();
    repeat (3) wheel_step(1'b1);
    wheel_step(1'b0);
    // out of step: opposite phase
    sample(pins_now, phase_now ^ 2'b11, 1'b0, 1'b1);
    // no pending interrupt, nothing sampled
    sample(pins_now ^ 8'h01, STEP_FWD[phase_now], 1'b0, 1'b0);
    read_one();
    repeat (3) wheel_step(1'b0);
    read_one();
    sample(8'h7e, STEP_FWD[phase_now], 1'b1, 1'b1);
    sample(8'h7d, phase_now, 1'b1, 1'b0);
    sample(8'h7f, phase_now, 1'b1, 1'b0);
    repeat (3) read_one();

    // disabled: no events queued, reads still answered
    set_enable(1'b0);
    repeat (100) random_item();
    set_enable(1'b1);

    for (int i = 0; i < 800; i++) begin
      if (i == 250) begin
        rx_long_hold = 1'b1;
        repeat (15) read_one();
      end
      if (i == 500) drain(0);
      random_item();
    end

    // scroll saturation in both directions
    repeat (32) read_one();
    sample(8'h7f, phase_now, 1'b1, 1'b0);
    repeat (135) wheel_step(1'b1);
    read_one();
    repeat (135) wheel_step(1'b0);
    read_one();

    // overflow the store, then drain it
    for (int i = 0; i < 40; i++) begin
      sample(pins_now ^ (8'h01 << $urandom_range(0, 6)), 2'($urandom), 1'b1, 1'b0);
    end
    repeat (36) read_one();

    quiet = 1'b1;
    repeat (120) random_item();

    drain(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
